/* src/asgd_pkg.sv */
// Shared constants, types and the digit split function for the gadget decomposer.
package asgd_pkg;

	// Field and register widths
	localparam int VAL_W     = 54;
	localparam int MOD_W     = 55;
	localparam int BITS_W    = 6;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	// Signed working width: holds c - Q and the rounding carry with margin
	localparam int SW        = 58;

	localparam int MAX_DIGITS = 16;
	localparam int TOTAL_BITS = 54;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int CRED_W = $clog2(QDEPTH + 1);

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd2;

	// Reset values of the registers
	localparam logic [MOD_W-1:0]  RST_MODULUS     = MOD_W'(1) << 54;
	localparam logic [BITS_W-1:0] RST_DIGIT_BITS  = BITS_W'(9);
	localparam logic [CNT_W-1:0]  RST_DIGIT_COUNT = CNT_W'(6);

	typedef logic signed [SW-1:0] sval_t;

	// Settings derived from the registers, shared by front and back
	typedef struct packed {
		logic [MOD_W-1:0]  modulus;
		logic [MOD_W-1:0]  half;
		logic [BITS_W-1:0] bits;
		logic [CNT_W-1:0]  count;
		logic [BITS_W-1:0] ignore;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		sval_t digit;
		sval_t rest;
	} split_t;

	// Split off the sign-extended low w bits; rest is the rounded upper part.
	// w of zero gives a zero digit and leaves the value untouched.
	function automatic split_t split_low(sval_t v, logic [BITS_W-1:0] w);
		logic [SW-1:0]     mask;
		logic [BITS_W-1:0] sel;
		logic              sgn;
		split_t            res;
		mask = ~({SW{1'b1}} << w);
		sel  = (w >= BITS_W'(SW)) ? BITS_W'(SW - 1) : (w - BITS_W'(1));
		sgn  = v[sel];
		if (w == '0) begin
			res.digit = '0;
			res.rest  = v;
		end else begin
			res.digit = sgn ? (v | sval_t'(~mask)) : (v & sval_t'(mask));
			res.rest  = (v >>> w) + sval_t'({{(SW - 1){1'b0}}, sgn});
		end
		return res;
	endfunction

endpackage

/* src/asgd_front.sv */
// Front end: takes coefficients, centers them and drops the ignored low bits.
module asgd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [asgd_pkg::VAL_W-1:0] coefficient,
	input  asgd_pkg::cfg_t            cfg,
	input  logic                      pop,
	output logic                      push,
	output asgd_pkg::sval_t           push_data
);
	import asgd_pkg::*;

	logic              accept;
	logic              drop;
	logic [CRED_W-1:0] inflight_q;
	logic              valid_s1;
	logic              valid_s2;
	sval_t             v_s1;
	sval_t             v_s2;
	sval_t             centered;
	split_t            dropped;

	// Items between acceptance and leaving the queue, bounded by queue depth
	assign busy   = (inflight_q == CRED_W'(QDEPTH));
	assign accept = start & ~busy;
	assign push   = valid_s2 & (cfg.count != '0);
	assign drop   = valid_s2 & (cfg.count == '0);
	assign push_data = v_s2;

	// Centering: values at or above floor(Q/2) go negative
	assign centered = ({1'b0, coefficient} < cfg.half) ? sval_t'(coefficient)
		: (sval_t'(coefficient) - sval_t'(cfg.modulus));

	assign dropped = split_low(v_s1, cfg.ignore);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			inflight_q <= inflight_q + CRED_W'(accept) - CRED_W'(pop) - CRED_W'(drop);
			valid_s1   <= accept;
			valid_s2   <= valid_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		v_s1 <= centered;
		v_s2 <= dropped.rest;
	end

endmodule

/* src/asgd_queue.sv */
// Short FIFO of rounded values between the front end and the digit engine.
module asgd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  asgd_pkg::sval_t     push_data,
	input  logic                pop,
	output asgd_pkg::sval_t     head,
	output asgd_pkg::q_status_t status
);
	import asgd_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	sval_t             entries_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CRED_W-1:0] fill_q;

	assign head        = entries_q[rd_ptr_q];
	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == CRED_W'(QDEPTH));

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CRED_W'(push) - CRED_W'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Front credit must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full || pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue pop while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CRED_W'(QDEPTH))
		else $error("queue fill above depth");

endmodule

/* src/asgd_back.sv */
// Digit engine: peels one signed digit per cycle and drives the result ports.
module asgd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  asgd_pkg::cfg_t             cfg,
	input  asgd_pkg::sval_t            head,
	input  asgd_pkg::q_status_t        status,
	output logic                       pop,
	output logic                       digit_valid,
	output logic [asgd_pkg::VAL_W-1:0] digit_value,
	output logic [asgd_pkg::IDX_W-1:0] digit_index,
	output logic                       last_digit
);
	import asgd_pkg::*;

	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	sval_t            v_q;
	split_t           sp;
	sval_t            lifted;
	logic             last;
	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] index_q;
	logic             last_q;

	assign sp     = split_low(v_q, cfg.bits);
	assign lifted = sp.digit + sval_t'(cfg.modulus);
	assign last   = (CNT_W'(idx_q) == cfg.count - CNT_W'(1));

	// Load the next item as soon as the current one gives its last digit
	assign pop = (~active_q | last) & ~status.empty;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= active_q;
			priority if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	// Working value and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			v_q <= head;
		end else if (active_q) begin
			v_q <= sp.rest;
		end
		// negative digit is lifted by Q
		value_q <= sp.digit[SW-1] ? lifted[VAL_W-1:0] : sp.digit[VAL_W-1:0];
		index_q <= idx_q;
		last_q  <= last;
	end

	assign digit_valid = valid_q;
	assign digit_value = value_q;
	assign digit_index = index_q;
	assign last_digit  = last_q;

endmodule

/* src/approx_signed_gadget_decompose_core.sv */
// Top level of the approximate signed gadget decomposer.
//
// Input: a coefficient is taken at a rising edge with start high and busy low.
// Output: each digit is shown for one cycle with digit_valid high, lowest
// digit first, with digit_index on each and last_digit on the final one. The
// receiver cannot hold results off.
// Config: cfg_valid/cfg_ready write channel; cfg_index 0 modulus, 1 digit_bits,
// 2 digit_count, 3 ignored. cfg_ready is always high. Write only while idle.
// Path: with the engine idle, a coefficient is centered at the accepting
// edge, then rounded, queued, loaded into the engine and put in the output
// register, after which its first digit is on the ports.
// Throughput: the digit engine gives one digit per cycle, and a coefficient
// gives min(digit_count, 16) digits; a count of zero gives no digits and
// takes no engine time. Up to four coefficients may be in flight; busy
// rises when all four slots are taken.
// Reset: registers return to modulus 2^54, digit_bits 9, digit_count 6 and
// all in-flight items are dropped.
module approx_signed_gadget_decompose_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [asgd_pkg::VAL_W-1:0]     coefficient,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [asgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [asgd_pkg::MOD_W-1:0]     cfg_data,
	output logic                           digit_valid,
	output logic [asgd_pkg::VAL_W-1:0]     digit_value,
	output logic [asgd_pkg::IDX_W-1:0]     digit_index,
	output logic                           last_digit
);
	import asgd_pkg::*;

	localparam int USED_W = CNT_W + BITS_W;

	logic [MOD_W-1:0]  modulus_q;
	logic [BITS_W-1:0] digit_bits_q;
	logic [CNT_W-1:0]  digit_count_q;
	logic [CNT_W-1:0]  count_eff;
	logic [USED_W-1:0] used;
	cfg_t              cfg;
	logic              push;
	logic              pop;
	sval_t             push_data;
	sval_t             head;
	q_status_t         status;

	assign cfg_ready = 1'b1;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= RST_MODULUS;
			digit_bits_q  <= RST_DIGIT_BITS;
			digit_count_q <= RST_DIGIT_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:     modulus_q     <= cfg_data;
				REG_DIGIT_BITS:  digit_bits_q  <= cfg_data[BITS_W-1:0];
				REG_DIGIT_COUNT: digit_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived settings: clamped count and dropped width
	assign count_eff = (digit_count_q > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
		: digit_count_q;
	assign used = USED_W'(count_eff) * USED_W'(digit_bits_q);

	always_comb begin
		cfg.modulus = modulus_q;
		cfg.half    = modulus_q >> 1;
		cfg.bits    = digit_bits_q;
		cfg.count   = count_eff;
		cfg.ignore  = (used >= USED_W'(TOTAL_BITS)) ? '0
			: BITS_W'(USED_W'(TOTAL_BITS) - used);
	end

	asgd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.coefficient (coefficient),
		.cfg         (cfg),
		.pop         (pop),
		.push        (push),
		.push_data   (push_data)
	);

	asgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	asgd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head        (head),
		.status      (status),
		.pop         (pop),
		.digit_valid (digit_valid),
		.digit_value (digit_value),
		.digit_index (digit_index),
		.last_digit  (last_digit)
	);

endmodule
